// ===== rtl/core/bced_pkg.sv =====
// ----------------------------------------------------------------------------
// bced_pkg
// Shared types, constants and helpers for the button click event detector.
// ----------------------------------------------------------------------------
package bced_pkg;

  // Significant bits of a key sample (1..12; larger values are capped at the 12-bit port width)
  localparam int SAMPLE_BITS = 12;
  localparam int IN_W        = 12;
  localparam int SMP_W       = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
  localparam int DELTA_W     = 12;
  // Window sums are one bit wider than the widest operand, so they never wrap
  localparam int SUM_W       = ((SMP_W > DELTA_W) ? SMP_W : DELTA_W) + 1;

  localparam int FILT_W = 8;
  localparam int TICK_W = 16;
  localparam int REP_W  = 8;
  localparam int EV_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [FILT_W-1:0] FILT_MAX = '1;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [REP_W-1:0]  REP_MAX  = '1;
  localparam logic [REP_W-1:0]  REP_ONE  = REP_W'(1);
  localparam logic [REP_W-1:0]  REP_TWO  = REP_W'(2);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DETECT_MODE  = 3'd0,
    REG_ACTIVE_LEVEL = 3'd1,
    REG_WINDOW_DELTA = 3'd2,
    REG_FILTER_TICKS = 3'd3,
    REG_SHORT_TICKS  = 3'd4,
    REG_LONG_TICKS   = 3'd5
  } reg_idx_t;

  // Reported event codes
  typedef enum logic [EV_W-1:0] {
    EV_NONE       = 3'd0,
    EV_DOWN       = 3'd1,
    EV_UP         = 3'd2,
    EV_SINGLE     = 3'd3,
    EV_DOUBLE     = 3'd4,
    EV_LONG_START = 3'd5,
    EV_LONG_HOLD  = 3'd6
  } event_t;

  // Click state machine
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PRESS   = 3'd1,
    ST_RELEASE = 3'd2,
    ST_REPEAT  = 3'd3,
    ST_LONG    = 3'd5
  } fsm_state_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic                 detect_mode;
    logic [IN_W-1:0]      press_level;
    logic [DELTA_W-1:0]   window_delta;
    logic [FILT_W-1:0]    filter_ticks;
    logic [TICK_W-1:0]    short_ticks;
    logic [TICK_W-1:0]    long_ticks;
  } cfg_t;

  // True when x lies in [a - d, a + d], compared without wrap
  function automatic logic in_window(logic [SMP_W-1:0] x, logic [SMP_W-1:0] a,
                                     logic [DELTA_W-1:0] d);
    logic [SUM_W-1:0] xd;
    logic [SUM_W-1:0] ad;
    xd = SUM_W'(x) + SUM_W'(d);
    ad = SUM_W'(a) + SUM_W'(d);
    return (xd >= SUM_W'(a)) && (SUM_W'(x) <= ad);
  endfunction

endpackage

// ===== rtl/core/bced_debounce.sv =====
// ----------------------------------------------------------------------------
// bced_debounce
// Sample filter: accepts a new key level after enough differing samples and
// reports whether the accepted level means "pressed".
// ----------------------------------------------------------------------------
module bced_debounce import bced_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [IN_W-1:0]  sample,
  input  cfg_t             cfg,
  output logic             pressed
);

  logic [SMP_W-1:0]  deb_r,  deb_nxt;
  logic [FILT_W-1:0] filt_r, filt_nxt;

  logic [SMP_W-1:0]  smp;
  logic [SMP_W-1:0]  act;
  logic              win_s, win_d;
  logic              differ;
  logic              take_new;
  logic [FILT_W-1:0] filt_inc;

  assign smp   = sample[SMP_W-1:0];
  assign act   = cfg.press_level[SMP_W-1:0];
  assign win_s = in_window(smp,   act, cfg.window_delta);
  assign win_d = in_window(deb_r, act, cfg.window_delta);

  // Difference test depends on compare mode
  assign differ   = cfg.detect_mode ? (win_s != win_d) : (smp != deb_r);
  assign filt_inc = (filt_r < FILT_MAX) ? filt_r + FILT_W'(1) : filt_r;
  assign take_new = differ && (filt_inc >= cfg.filter_ticks);

  // Filter count and accepted level
  always_comb begin
    deb_nxt  = deb_r;
    filt_nxt = '0;
    if (take_new) begin
      deb_nxt = smp;
    end else if (differ) begin
      filt_nxt = filt_inc;
    end
  end

  // Pressed test on the level as updated by this sample
  always_comb begin
    if (cfg.detect_mode) begin
      pressed = take_new ? win_s : win_d;
    end else begin
      pressed = (deb_nxt == act);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= '0;
      filt_r <= '0;
    end else if (step) begin
      deb_r  <= deb_nxt;
      filt_r <= filt_nxt;
    end
  end

endmodule

// ===== rtl/core/bced_fsm.sv =====
// ----------------------------------------------------------------------------
// bced_fsm
// Press / release / repeat / long-press state machine with tick and click
// counters; holds the reported event.
// ----------------------------------------------------------------------------
module bced_fsm import bced_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             pressed,
  input  cfg_t             cfg,
  output logic [EV_W-1:0]  event_code,
  output logic [REP_W-1:0] click_count
);

  fsm_state_t        state_r, state_nxt;
  logic [TICK_W-1:0] tick_r,  tick_nxt;
  logic [REP_W-1:0]  rep_r,   rep_nxt;
  event_t            ev_r,    ev_nxt;

  logic [TICK_W-1:0] tick_inc;

  // Tick counter runs outside idle and saturates
  assign tick_inc = ((state_r != ST_IDLE) && (tick_r < TICK_MAX)) ?
                    tick_r + TICK_W'(1) : tick_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pressed) state_nxt = ST_PRESS;
      end
      ST_PRESS: begin
        if (!pressed) state_nxt = ST_RELEASE;
        else if (tick_inc > cfg.long_ticks) state_nxt = ST_LONG;
      end
      ST_RELEASE: begin
        if (pressed) state_nxt = ST_REPEAT;
        else if (tick_inc > cfg.short_ticks) state_nxt = ST_IDLE;
      end
      ST_REPEAT: begin
        if (!pressed) begin
          state_nxt = (tick_inc < cfg.short_ticks) ? ST_RELEASE : ST_IDLE;
        end else if (tick_inc > cfg.short_ticks) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LONG: begin
        if (!pressed) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Event, tick and click count updates
  always_comb begin
    ev_nxt   = ev_r;
    tick_nxt = tick_inc;
    rep_nxt  = rep_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pressed) begin
          ev_nxt   = EV_DOWN;
          tick_nxt = '0;
          rep_nxt  = REP_ONE;
        end else begin
          ev_nxt = EV_NONE;
        end
      end
      ST_PRESS: begin
        if (!pressed) begin
          ev_nxt   = EV_UP;
          tick_nxt = '0;
        end else if (tick_inc > cfg.long_ticks) begin
          ev_nxt = EV_LONG_START;
        end
      end
      ST_RELEASE: begin
        if (pressed) begin
          ev_nxt   = EV_DOWN;
          tick_nxt = '0;
          if (rep_r < REP_MAX) rep_nxt = rep_r + REP_W'(1);
        end else if (tick_inc > cfg.short_ticks) begin
          if (rep_r == REP_ONE) ev_nxt = EV_SINGLE;
          else if (rep_r == REP_TWO) ev_nxt = EV_DOUBLE;
        end
      end
      ST_REPEAT: begin
        if (!pressed) begin
          ev_nxt = EV_UP;
          if (tick_inc < cfg.short_ticks) tick_nxt = '0;
        end
      end
      ST_LONG: begin
        ev_nxt = pressed ? EV_LONG_HOLD : EV_UP;
      end
      default: ev_nxt = ev_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tick_r  <= '0;
      rep_r   <= '0;
      ev_r    <= EV_NONE;
    end else if (step) begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      rep_r   <= rep_nxt;
      ev_r    <= ev_nxt;
    end
  end

  assign event_code  = ev_r;
  assign click_count = rep_r;

endmodule

// ===== rtl/core/button_click_event_detector.sv =====
// ----------------------------------------------------------------------------
// button_click_event_detector
// Debounced key sampler that reports press, release, click and long-press
// events, one result per sample.
// ----------------------------------------------------------------------------
// Each accepted sample produces exactly one result, presented on the cycle
// after the transfer. A new sample is taken in every cycle in which the
// output is empty or its result is being taken, so the block sustains one
// sample per clock; the single register stage that holds the filter, state
// machine and event is what sets that figure. The reported event holds its
// previous value when no transition fires, except in idle (no event) and
// long press (hold). Configuration writes are always accepted and should be
// made while no sample is in flight. There is no clearing pass after reset.
module button_click_event_detector import bced_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IN_W-1:0]       in_sample_level,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [EV_W-1:0]       out_event_code,
  output logic [REP_W-1:0]      out_click_count,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_xfer;
  logic pressed;

  // Register writes
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DETECT_MODE:  cfg_nxt.detect_mode  = cfg_data[0];
        REG_ACTIVE_LEVEL: cfg_nxt.press_level  = cfg_data[IN_W-1:0];
        REG_WINDOW_DELTA: cfg_nxt.window_delta = cfg_data[DELTA_W-1:0];
        REG_FILTER_TICKS: cfg_nxt.filter_ticks = cfg_data[FILT_W-1:0];
        REG_SHORT_TICKS:  cfg_nxt.short_ticks  = cfg_data[TICK_W-1:0];
        REG_LONG_TICKS:   cfg_nxt.long_ticks   = cfg_data[TICK_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_mode  <= 1'b0;
      cfg_r.press_level  <= '0;
      cfg_r.window_delta <= DELTA_W'(100);
      cfg_r.filter_ticks <= FILT_W'(3);
      cfg_r.short_ticks  <= TICK_W'(30);
      cfg_r.long_ticks   <= TICK_W'(100);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshake: take a sample when the result slot is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Sample filter
  bced_debounce u_debounce (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_xfer),
    .sample  (in_sample_level),
    .cfg     (cfg_r),
    .pressed (pressed)
  );

  // Event state machine; its registers are the result register
  bced_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_xfer),
    .pressed     (pressed),
    .cfg         (cfg_r),
    .event_code  (out_event_code),
    .click_count (out_click_count)
  );

endmodule
